// ----- rtl/sdiv_pkg.sv -----
package sdiv_pkg;

   // Per-beat control that travels down the divider pipeline beside the data.
   typedef struct packed {
      logic valid;
      logic dividend_neg;
      logic divisor_neg;
      logic div_zero;
   } sdiv_ctrl_type;

endpackage

// ----- rtl/signed_restoring_divider.sv -----
// Signed restoring divider, fully pipelined. A dividend/divisor beat is taken
// on every clock edge where start is high; busy is never asserted, so a new
// beat may be issued every cycle. Each beat produces exactly one result beat
// on the rsp_ ports, marked by rsp_strobe for a single cycle. The path holds
// WIDTH+2 register stages: one stage forms the operand magnitudes, WIDTH
// stages each perform one restoring shift/subtract step, and one stage
// applies the quotient sign. The receiver cannot stall the result and must
// capture it in the cycle that rsp_strobe is high. The quotient is
// truncated toward zero; the remainder is the unsigned magnitude of the
// magnitude division. A zero divisor raises rsp_divide_by_zero, returns an
// all-ones quotient and the dividend magnitude as remainder. The single
// overflowing case (most negative dividend divided by -1) saturates the
// quotient to the largest positive value and raises rsp_overflow.
module signed_restoring_divider #(
   parameter int WIDTH = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic signed [WIDTH-1:0] req_dividend,
   input  logic signed [WIDTH-1:0] req_divisor,
   output logic                    rsp_strobe,
   output logic signed [WIDTH-1:0] rsp_quotient,
   output logic [WIDTH-1:0]        rsp_remainder,
   output logic                    rsp_divide_by_zero,
   output logic                    rsp_overflow
);

   localparam logic [WIDTH-1:0] QuoMax = {1'b0, {(WIDTH-1){1'b1}}};

   // Stage boundary k holds the state after k restoring steps.
   sdiv_pkg::sdiv_ctrl_type ctrl_chain [WIDTH+1];
   logic [WIDTH-1:0]        rem_chain  [WIDTH+1];
   logic [WIDTH-1:0]        quo_chain  [WIDTH+1];
   logic [WIDTH-1:0]        div_chain  [WIDTH+1];

   // Input stage: latch the operand signs and take the magnitudes. The most
   // negative value maps to 2^(WIDTH-1), which still fits as unsigned.
   sdiv_pkg::sdiv_ctrl_type head_ctrl_ff, head_ctrl_in;
   logic [WIDTH-1:0]        head_quo_ff, head_quo_in;
   logic [WIDTH-1:0]        head_div_ff, head_div_in;

   always_comb begin
      head_quo_in = req_dividend[WIDTH-1] ? (~req_dividend + 1'b1) : req_dividend;
      head_div_in = req_divisor[WIDTH-1]  ? (~req_divisor + 1'b1)  : req_divisor;
      head_ctrl_in.valid        = start;
      head_ctrl_in.dividend_neg = req_dividend[WIDTH-1];
      head_ctrl_in.divisor_neg  = req_divisor[WIDTH-1];
      head_ctrl_in.div_zero     = (req_divisor == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ctrl_ff <= '0;
      end else begin
         head_ctrl_ff <= head_ctrl_in;
      end
      head_quo_ff <= head_quo_in;
      head_div_ff <= head_div_in;
   end

   // The partial remainder starts at zero; the dividend magnitude sits in the
   // quotient register and is shifted out one bit per step.
   assign ctrl_chain[0] = head_ctrl_ff;
   assign rem_chain[0]  = '0;
   assign quo_chain[0]  = head_quo_ff;
   assign div_chain[0]  = head_div_ff;

   for (genvar k = 0; k < WIDTH; k++) begin : g_step
      sdiv_step #(
         .WIDTH(WIDTH)
      ) u_step (
         .clock   (clock),
         .reset   (reset),
         .up_ctrl (ctrl_chain[k]),
         .up_rem  (rem_chain[k]),
         .up_quo  (quo_chain[k]),
         .up_div  (div_chain[k]),
         .dn_ctrl (ctrl_chain[k+1]),
         .dn_rem  (rem_chain[k+1]),
         .dn_quo  (quo_chain[k+1]),
         .dn_div  (div_chain[k+1])
      );
   end

   // Output stage: apply the sign. A zero divisor leaves the all-ones
   // quotient untouched. With equal signs a quotient magnitude that reaches
   // 2^(WIDTH-1) cannot be represented and is saturated.
   sdiv_pkg::sdiv_ctrl_type tail_ctrl;
   logic [WIDTH-1:0]        tail_quo;
   logic                    strobe_ff;
   logic [WIDTH-1:0]        quo_ff, quo_in;
   logic [WIDTH-1:0]        rem_ff;
   logic                    dbz_ff;
   logic                    ovf_ff, ovf_in;

   assign tail_ctrl = ctrl_chain[WIDTH];
   assign tail_quo  = quo_chain[WIDTH];

   always_comb begin
      ovf_in = 1'b0;
      if (tail_ctrl.div_zero) begin
         quo_in = tail_quo;
      end else if (tail_ctrl.dividend_neg != tail_ctrl.divisor_neg) begin
         quo_in = ~tail_quo + 1'b1;
      end else if (tail_quo[WIDTH-1]) begin
         quo_in = QuoMax;
         ovf_in = 1'b1;
      end else begin
         quo_in = tail_quo;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= tail_ctrl.valid;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_chain[WIDTH];
      dbz_ff <= tail_ctrl.div_zero;
      ovf_ff <= ovf_in;
   end

   // Every stage advances each cycle, so the divider never pushes back.
   assign busy               = 1'b0;
   assign rsp_strobe         = strobe_ff;
   assign rsp_quotient       = quo_ff;
   assign rsp_remainder      = rem_ff;
   assign rsp_divide_by_zero = dbz_ff;
   assign rsp_overflow       = ovf_ff;

endmodule

// ----- rtl/sdiv_step.sv -----
module sdiv_step #(
   parameter int WIDTH = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  sdiv_pkg::sdiv_ctrl_type   up_ctrl,
   input  logic [WIDTH-1:0]          up_rem,
   input  logic [WIDTH-1:0]          up_quo,
   input  logic [WIDTH-1:0]          up_div,
   output sdiv_pkg::sdiv_ctrl_type   dn_ctrl,
   output logic [WIDTH-1:0]          dn_rem,
   output logic [WIDTH-1:0]          dn_quo,
   output logic [WIDTH-1:0]          dn_div
);

   sdiv_pkg::sdiv_ctrl_type ctrl_ff;
   logic [WIDTH-1:0]        rem_ff, rem_in;
   logic [WIDTH-1:0]        quo_ff, quo_in;
   logic [WIDTH-1:0]        div_ff;
   logic [WIDTH-1:0]        shifted;
   logic [WIDTH:0]          trial;

   // One restoring step: shift the partial remainder left, bringing in the
   // next dividend bit, and keep the difference only when it did not borrow.
   always_comb begin
      shifted = {up_rem[WIDTH-2:0], up_quo[WIDTH-1]};
      trial   = {1'b0, shifted} - {1'b0, up_div};
      if (trial[WIDTH]) begin
         rem_in = shifted;
         quo_in = {up_quo[WIDTH-2:0], 1'b0};
      end else begin
         rem_in = trial[WIDTH-1:0];
         quo_in = {up_quo[WIDTH-2:0], 1'b1};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else begin
         ctrl_ff <= up_ctrl;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= up_div;
   end

   assign dn_ctrl = ctrl_ff;
   assign dn_rem  = rem_ff;
   assign dn_quo  = quo_ff;
   assign dn_div  = div_ff;

endmodule

// ----- rtl/sdiv_checker.sv -----
module sdiv_checker #(
   parameter int WIDTH = 16
) (
   input logic                    clock,
   input logic                    reset,
   input logic                    start,
   input logic                    busy,
   input logic signed [WIDTH-1:0] req_dividend,
   input logic signed [WIDTH-1:0] req_divisor,
   input logic                    rsp_strobe,
   input logic signed [WIDTH-1:0] rsp_quotient,
   input logic [WIDTH-1:0]        rsp_remainder,
   input logic                    rsp_divide_by_zero,
   input logic                    rsp_overflow
);

   localparam int Latency = WIDTH + 2;
   localparam int SettleW = $clog2(Latency + 2);
   localparam logic [SettleW-1:0] Settled = SettleW'(Latency + 1);
   localparam logic [WIDTH-1:0]   QuoMax  = {1'b0, {(WIDTH-1){1'b1}}};

   // Counts cycles since reset so history checks skip flushed beats.
   logic [SettleW-1:0] settle_ff, settle_in;

   assign settle_in = (settle_ff == Settled) ? settle_ff : settle_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         settle_ff <= '0;
      end else begin
         settle_ff <= settle_in;
      end
   end

   a_never_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("divider raised busy");

   a_one_result_per_beat: assert property (@(posedge clock) disable iff (reset)
      (settle_ff == Settled) |-> (rsp_strobe == $past(start && !busy, Latency)))
      else $error("result beat does not match accepted beat");

   a_dbz_matches_divisor: assert property (@(posedge clock) disable iff (reset)
      (settle_ff == Settled && rsp_strobe)
         |-> (rsp_divide_by_zero == ($past(req_divisor, Latency) == '0)))
      else $error("divide-by-zero flag does not match divisor");

   a_dbz_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_divide_by_zero) |-> (!rsp_overflow && (&rsp_quotient)))
      else $error("divide-by-zero result malformed");

   a_ovf_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_overflow)
         |-> (rsp_quotient == QuoMax && rsp_remainder == '0))
      else $error("overflow result not saturated");

endmodule

bind signed_restoring_divider sdiv_checker #(
   .WIDTH(WIDTH)
) u_sdiv_checker (
   .clock              (clock),
   .reset              (reset),
   .start              (start),
   .busy               (busy),
   .req_dividend       (req_dividend),
   .req_divisor        (req_divisor),
   .rsp_strobe         (rsp_strobe),
   .rsp_quotient       (rsp_quotient),
   .rsp_remainder      (rsp_remainder),
   .rsp_divide_by_zero (rsp_divide_by_zero),
   .rsp_overflow       (rsp_overflow)
);
